@@ rtl/order_preserving_varint_encoder_unit_defines.svh @@
// assertion macros for the order preserving varint encoder
// used by files that carry concurrent checks; no other dependencies
`ifndef ORDER_PRESERVING_VARINT_ENCODER_UNIT_DEFINES_SVH
`define ORDER_PRESERVING_VARINT_ENCODER_UNIT_DEFINES_SVH

// check that is held off while reset is high
`define OPVE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check that also runs during reset
`define OPVE_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ rtl/opve_pkg.sv @@
// shared types and constants of the order preserving varint encoder
// no dependencies
package opve_pkg;

   localparam int          BODY_BYTES    = 8;
   localparam int          VALUE_WIDTH   = 64;
   localparam int          LEN_WIDTH     = 4;
   localparam logic [7:0]  TAG_MIN_BASE  = 8'h80;
   localparam logic [7:0]  TAG_ZERO      = 8'd136;
   localparam logic [7:0]  TAG_MAX_BASE  = 8'hfd;
   localparam logic [63:0] SMALL_LIMIT   = 64'd109;

   // positions in the request tuser field
   localparam int USER_KIND_BIT = 0;
   localparam int USER_DESC_BIT = 1;
   localparam int USER_WIDTH    = 2;

   // encoded key: tag byte, body left aligned, body byte count
   typedef struct packed {
      logic [7:0]             tag;
      logic [VALUE_WIDTH-1:0] body;
      logic [LEN_WIDTH-1:0]   len;
   } enc_type;

endpackage

@@ rtl/order_preserving_varint_encoder_unit.sv @@
// Order preserving varint key encoder. Each request carries a 64-bit value
// with a signed/unsigned kind and an ascending/descending flag and yields a
// memcomparable key of 1 to 9 bytes (tag byte, then big-endian body bytes),
// sent one byte per rsp transfer with rsp_tlast on the final byte. A request
// enters an input register, is encoded in one pass and loaded into an output
// shift stage; the next request is taken while the previous key drains. The
// first byte is registered in the input register and then in the output shift
// stage. A key is 1 + L bytes (L = body bytes, 0 to 8), each held on the rsp
// port until rsp_tready. Depends on opve_pkg, opve_encode and the defines
// header.
`include "order_preserving_varint_encoder_unit_defines.svh"

module order_preserving_varint_encoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [opve_pkg::VALUE_WIDTH-1:0]  req_tdata,  // value
   input  logic [opve_pkg::USER_WIDTH-1:0]   req_tuser,  // kind, descending
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // out_byte
   output logic                              rsp_tlast
);
   import opve_pkg::*;

   logic                   in_valid_ff;
   logic [VALUE_WIDTH-1:0] in_value_ff;
   logic                   in_kind_ff;
   logic                   in_desc_ff;

   logic                   out_valid_ff;
   logic                   tag_phase_ff;
   logic [7:0]             tag_ff;
   logic [VALUE_WIDTH-1:0] body_ff;
   logic [LEN_WIDTH-1:0]   rem_ff;

   logic                   tag_phase_in;
   logic [VALUE_WIDTH-1:0] body_in;
   logic [LEN_WIDTH-1:0]   rem_in;

   enc_type                enc;
   logic                   req_fire;
   logic                   rsp_fire;
   logic                   done;
   logic                   load;

   opve_encode u_encode (
      .value      (in_value_ff),
      .kind       (in_kind_ff),
      .descending (in_desc_ff),
      .enc        (enc)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = tag_phase_ff ? tag_ff : body_ff[VALUE_WIDTH-1 -: 8];
   assign rsp_tlast  = tag_phase_ff ? (rem_ff == '0) : (rem_ff == LEN_WIDTH'(1));

   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign done       = rsp_fire && rsp_tlast;
   assign load       = in_valid_ff && (!out_valid_ff || done);
   assign req_tready = !in_valid_ff || load;
   assign req_fire   = req_tvalid && req_tready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_fire) begin
         in_value_ff <= req_tdata;
         in_kind_ff  <= req_tuser[USER_KIND_BIT];
         in_desc_ff  <= req_tuser[USER_DESC_BIT];
      end
   end

   // output shift stage next values
   always_comb begin
      tag_phase_in = tag_phase_ff;
      body_in      = body_ff;
      rem_in       = rem_ff;
      if (load) begin
         tag_phase_in = 1'b1;
         body_in      = enc.body;
         rem_in       = enc.len;
      end else if (rsp_fire && !rsp_tlast) begin
         if (tag_phase_ff) begin
            tag_phase_in = 1'b0;
         end else begin
            body_in = {body_ff[VALUE_WIDTH-9:0], 8'd0};
            rem_in  = rem_ff - LEN_WIDTH'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         tag_phase_ff <= 1'b1;
         rem_ff       <= '0;
      end else begin
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (done) begin
            out_valid_ff <= 1'b0;
         end
         tag_phase_ff <= tag_phase_in;
         rem_ff       <= rem_in;
      end
      body_ff <= body_in;
      if (load) begin
         tag_ff <= enc.tag;
      end
   end

   `OPVE_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid && !in_valid_ff, "valid after reset")
   `OPVE_ASSERT(a_body_count, out_valid_ff && !tag_phase_ff |-> rem_ff != '0 && rem_ff <= LEN_WIDTH'(BODY_BYTES), "bad body count")
   `OPVE_ASSERT(a_body_step, rsp_fire && !tag_phase_ff && !rsp_tlast |=> rem_ff == $past(rem_ff) - LEN_WIDTH'(1), "body count skip")
   `OPVE_ASSERT(a_drain_end, done && !load |=> !rsp_tvalid, "response after last byte")

endmodule

@@ rtl/opve_encode.sv @@
// combinational key encoder: tag byte, body bytes and body length of one value
// depends on opve_pkg
module opve_encode (
   input  logic [opve_pkg::VALUE_WIDTH-1:0] value,
   input  logic                             kind,
   input  logic                             descending,
   output opve_pkg::enc_type                enc
);
   import opve_pkg::*;

   logic [VALUE_WIDTH-1:0] v;
   logic [VALUE_WIDTH-1:0] mag;
   logic [VALUE_WIDTH-1:0] body;
   logic [LEN_WIDTH-1:0]   cnt;
   logic [LEN_WIDTH-1:0]   len;
   logic [7:0]             tag;
   logic [6:0]             lsh;
   logic                   neg;
   logic                   udesc;

   assign v     = (kind && descending) ? ~value : value;
   assign neg   = kind && v[VALUE_WIDTH-1];
   assign udesc = !kind && descending;
   assign mag   = neg ? (64'd0 - v) : v;
   assign body  = udesc ? ~v : v;

   // significant byte count of the magnitude
   always_comb begin
      cnt = LEN_WIDTH'(1);
      for (int i = 1; i < BODY_BYTES; i++) begin
         if (mag[8*i +: 8] != 8'd0) begin
            cnt = LEN_WIDTH'(i + 1);
         end
      end
   end

   always_comb begin
      priority if (neg) begin
         len = cnt;
         tag = 8'(TAG_MIN_BASE + 8'(BODY_BYTES) - {4'd0, cnt});
      end else if (udesc) begin
         if (v == 64'd0) begin
            len = '0;
            tag = TAG_ZERO;
         end else begin
            len = cnt;
            tag = 8'(TAG_ZERO - {4'd0, cnt});
         end
      end else begin
         if (v <= SMALL_LIMIT) begin
            len = '0;
            tag = 8'(TAG_ZERO + v[7:0]);
         end else begin
            len = cnt;
            tag = 8'(TAG_MAX_BASE - 8'(BODY_BYTES) + {4'd0, cnt});
         end
      end
   end

   // move the first body byte to the top of the word
   assign lsh = {4'(4'(BODY_BYTES) - len), 3'b000};

   assign enc.tag  = tag;
   assign enc.len  = len;
   assign enc.body = body << lsh;

endmodule

@@ sim/tb_top.sv @@
// self-checking testbench for order_preserving_varint_encoder_unit
// predicts each key's tag and body bytes and checks the byte stream in order
// depends on opve_pkg and the encoder rtl
module tb_top;
   import opve_pkg::*;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   is_signed;
      logic                   desc;
   } key_req_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } key_byte_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [VALUE_WIDTH-1:0] req_tdata  = '0;
   logic [USER_WIDTH-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;

   key_req_type  pending_reqs[$];
   key_byte_type key_bytes[$];
   int unsigned n_queued    = 0;
   int unsigned n_accepted  = 0;
   int unsigned n_bytes     = 0;
   int unsigned n_errors    = 0;
   int unsigned n_long_keys = 0;
   int unsigned mode_count[4] = '{0, 0, 0, 0};
   int unsigned idle_pct    = 0;
   int unsigned stall_pct   = 0;
   bit          hold_rsp    = 1'b0;
   bit          req_fire    = 1'b0;

   order_preserving_varint_encoder_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // value
      .req_tuser  (req_tuser),   // kind, descending
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // out_byte
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      reset = 1'b1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
   end

   initial begin
      #400000;
      $display("timeout with %0d bytes still expected", key_bytes.size());
      $display("TEST FAILED");
      $finish;
   end

   function automatic int unsigned sig_bytes(logic [63:0] x);
      int unsigned n;
      n = 1;
      while (n < 8 && (x >> (8 * n)) != 64'd0) n++;
      return n;
   endfunction

   function automatic void push_key(logic [7:0] tag, logic [63:0] body, int unsigned len);
      key_byte_type b;
      int unsigned  k;
      b.data = tag;
      b.last = (len == 0);
      key_bytes.insert(key_bytes.size(), b);
      for (k = 0; k < len; k++) begin
         b.data = body[8 * (len - 1 - k) +: 8];
         b.last = (k + 1 == len);
         key_bytes.insert(key_bytes.size(), b);
      end
   endfunction

   function automatic void encode_unsigned_asc(logic [63:0] n);
      int unsigned len;
      if (n <= SMALL_LIMIT) begin
         push_key(8'(TAG_ZERO + n[7:0]), '0, 0);
      end else begin
         len = sig_bytes(n);
         push_key(8'(TAG_MAX_BASE - 8 + len), n, len);
      end
   endfunction

   function automatic void predict_key(key_req_type r);
      logic [63:0] v;
      int unsigned len;
      if (r.is_signed) begin
         v = r.desc ? ~r.value : r.value;
         if (v[63]) begin
            len = sig_bytes(64'd0 - v);
            push_key(8'(TAG_MIN_BASE + 8 - len), v, len);
         end else begin
            encode_unsigned_asc(v);
         end
      end else if (r.desc) begin
         if (r.value == 64'd0) begin
            push_key(TAG_ZERO, '0, 0);
         end else begin
            len = sig_bytes(r.value);
            push_key(8'(TAG_ZERO - len), ~r.value, len);
         end
      end else begin
         encode_unsigned_asc(r.value);
      end
   endfunction

   task automatic report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      n_errors++;
   endtask

   // request side: sample handshake, record expected key bytes
   always @(posedge clock) begin
      key_req_type r;
      int unsigned before_len;
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) begin
         r.value     = req_tdata;
         r.is_signed = req_tuser[USER_KIND_BIT];
         r.desc      = req_tuser[USER_DESC_BIT];
         before_len  = key_bytes.size();
         predict_key(r);
         if (key_bytes.size() - before_len == 9) n_long_keys++;
         mode_count[{r.is_signed, r.desc}]++;
         n_accepted++;
      end
   end

   // result side: compare each byte with the oldest expected one
   always @(posedge clock) begin
      key_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         n_bytes++;
         if (key_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected byte %02h last %0b",
                                      rsp_tdata, rsp_tlast));
         end else begin
            want = key_bytes.pop_front();
            if (rsp_tdata !== want.data)
               report_mismatch($sformatf("byte %02h, want %02h", rsp_tdata, want.data));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("last %0b, want %0b on byte %02h",
                                         rsp_tlast, want.last, want.data));
         end
      end
   end

   always @(negedge clock) begin
      key_req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
            r = pending_reqs.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= r.value;
            req_tuser  <= '0 | (USER_WIDTH'(r.is_signed) << USER_KIND_BIT)
                              | (USER_WIDTH'(r.desc) << USER_DESC_BIT);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset || hold_rsp)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   function automatic void queue_req(logic [63:0] value, logic is_signed, logic desc);
      key_req_type r;
      r.value     = value;
      r.is_signed = is_signed;
      r.desc      = desc;
      pending_reqs.insert(pending_reqs.size(), r);
      n_queued++;
   endfunction

   function automatic void queue_random_req();
      logic [63:0] mag;
      int unsigned len;
      logic        is_signed;
      logic        desc;
      is_signed = 1'($urandom_range(1));
      desc      = 1'($urandom_range(1));
      len       = $urandom_range(1, 8);
      mag       = {$urandom, $urandom};
      case ($urandom_range(5))
         0: begin
            mag = 64'($urandom_range(0, 120));
         end
         1: begin
            mag = (len == 8) ? 64'd0 : (64'd1 << (8 * len));
         end
         default: begin
            if (len < 8) mag = mag & ((64'd1 << (8 * len)) - 1);
            mag[8 * (len - 1) + $urandom_range(0, 7)] = 1'b1;
         end
      endcase
      if (is_signed && $urandom_range(1)) mag = 64'd0 - mag;
      queue_req(mag, is_signed, desc);
   endfunction

   task automatic wait_accepted();
      while (n_accepted != n_queued) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned idle, int unsigned stall, int unsigned count);
      int unsigned i;
      idle_pct  = idle;
      stall_pct = stall;
      for (i = 0; i < count; i++) queue_random_req();
      wait_accepted();
   endtask

   initial begin
      int unsigned waited;
      @(negedge reset);

      // directed corners: small-value boundary, byte-count edges, signed extremes
      queue_req(64'd0, 1'b0, 1'b0);
      queue_req(64'd109, 1'b0, 1'b0);
      queue_req(64'd110, 1'b0, 1'b0);
      queue_req(64'd255, 1'b0, 1'b0);
      queue_req(64'd256, 1'b0, 1'b0);
      queue_req(64'h0001_0000, 1'b0, 1'b0);
      queue_req('1, 1'b0, 1'b0);
      queue_req(64'h8000_0000_0000_0000, 1'b0, 1'b0);
      queue_req(64'd0, 1'b0, 1'b1);
      queue_req(64'd1, 1'b0, 1'b1);
      queue_req(64'd255, 1'b0, 1'b1);
      queue_req(64'd256, 1'b0, 1'b1);
      queue_req('1, 1'b0, 1'b1);
      queue_req('1, 1'b1, 1'b0);
      queue_req(-64'sd255, 1'b1, 1'b0);
      queue_req(-64'sd256, 1'b1, 1'b0);
      queue_req(64'h8000_0000_0000_0000, 1'b1, 1'b0);
      queue_req(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b0);
      queue_req(64'd109, 1'b1, 1'b0);
      queue_req(64'd0, 1'b1, 1'b1);
      queue_req('1, 1'b1, 1'b1);
      queue_req(64'h8000_0000_0000_0000, 1'b1, 1'b1);
      queue_req(64'h7fff_ffff_ffff_ffff, 1'b1, 1'b1);
      queue_req(64'd255, 1'b1, 1'b1);
      queue_req(64'h0000_0100_0000_0000, 1'b1, 1'b1);
      wait_accepted();

      run_phase(0, 0, 20);
      run_phase(48, 0, 20);
      run_phase(0, 48, 20);
      run_phase(19, 19, 20);

      // long receiver hold-off while requests keep coming
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      run_phase(0, 0, 20);

      waited = 0;
      while (key_bytes.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (20) @(posedge clock);
      if (key_bytes.size() != 0)
         report_mismatch($sformatf("%0d bytes never arrived", key_bytes.size()));

      $display("covered %0d requests (uns asc %0d, uns desc %0d, sgn asc %0d, sgn desc %0d)",
               n_accepted, mode_count[0], mode_count[1], mode_count[2], mode_count[3]);
      $display("checked %0d key bytes, %0d full nine-byte keys, %0d mismatches",
               n_bytes, n_long_keys, n_errors);
      if (n_errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
